/* sv/bbde_pkg.sv */
package bbde_pkg;

   localparam int VALUE_W       = 30;
   localparam int REQ_DATA_W    = 32;
   localparam int DIGIT_CHAR_W  = 7;
   localparam int DIGIT_VALUE_W = 4;
   localparam int RSP_DATA_W    = 16;

   // Digit places; the largest accepted magnitude is 9^(NUM_DIGITS-1)
   localparam int NUM_DIGITS = 10;
   // Ten balanced places cover every 30-bit input
   localparam int MAX_PLACES = 10;
   localparam int PLACES     = (NUM_DIGITS < MAX_PLACES) ? NUM_DIGITS : MAX_PLACES;
   localparam int PLACE_W    = $clog2(PLACES);
   localparam int DIGIT_MAX  = 4;
   localparam int SEL_W      = 3;
   localparam int TBL_W      = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIGIT_CHAR_W-1:0] CHAR_ZERO     = 7'h30;  // '0'
   localparam logic [DIGIT_CHAR_W-1:0] CHAR_NEG_BASE = 7'h60;  // 'a' - 1

   function automatic logic [63:0] pow9(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd9;
      end
      return p;
   endfunction

   localparam logic [63:0] MAX_POWER = pow9(NUM_DIGITS - 1);

   typedef logic [TBL_W-1:0] table_type [PLACES*8];

   // Entry {place, j}: smallest magnitude whose rounded digit at that place is j
   function automatic table_type make_thr_table();
      table_type t;
      for (int k = 0; k < PLACES; k++) begin
         for (int j = 0; j < 8; j++) begin
            if (j >= 1 && j <= DIGIT_MAX) begin
               t[k*8+j] = TBL_W'(((64'(2*j-1) * pow9(k)) + 64'd1) >> 1);
            end else begin
               t[k*8+j] = '0;
            end
         end
      end
      return t;
   endfunction

   // Entry {place, j}: j times the place weight
   function automatic table_type make_mult_table();
      table_type t;
      for (int k = 0; k < PLACES; k++) begin
         for (int j = 0; j < 8; j++) begin
            if (j <= DIGIT_MAX) begin
               t[k*8+j] = TBL_W'(64'(j) * pow9(k));
            end else begin
               t[k*8+j] = '0;
            end
         end
      end
      return t;
   endfunction

   localparam table_type THR_TABLE  = make_thr_table();
   localparam table_type MULT_TABLE = make_mult_table();

   typedef struct packed {
      logic               err;
      logic [VALUE_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

endpackage

/* sv/bbde_front.sv */
module bbde_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bbde_pkg::REQ_DATA_W-1:0]    req_tdata,   // [29:0] value
   output logic                               push_valid,
   output bbde_pkg::item_type                 push_item,
   input  logic                               push_ready
);

   logic [bbde_pkg::VALUE_W-1:0] value;
   logic [bbde_pkg::VALUE_W-1:0] mag;

   assign value = req_tdata[bbde_pkg::VALUE_W-1:0];
   assign mag   = value[bbde_pkg::VALUE_W-1] ? (~value + bbde_pkg::VALUE_W'(1)) : value;

   assign push_valid      = req_tvalid;
   assign push_item.value = value;
   // flag magnitudes beyond the top place weight
   assign push_item.err   = {{(64-bbde_pkg::VALUE_W){1'b0}}, mag} > bbde_pkg::MAX_POWER;
   assign req_tready      = push_ready;

endmodule

/* sv/bbde_queue.sv */
module bbde_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  bbde_pkg::item_type    push_item,
   output logic                  push_ready,
   output bbde_pkg::q_head_type  q_head,
   input  logic                  q_pop
);

   bbde_pkg::item_type                 entries_ff [bbde_pkg::QUEUE_DEPTH];
   logic [bbde_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [bbde_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [bbde_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               push;
   logic                               pop;

   assign push_ready  = count_ff != bbde_pkg::QCNT_W'(bbde_pkg::QUEUE_DEPTH);
   assign push        = push_valid && push_ready;
   assign pop         = q_pop && (count_ff != '0);
   assign q_head.valid = count_ff != '0;
   assign q_head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bbde_pkg::QPTR_W'(bbde_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + bbde_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bbde_pkg::QPTR_W'(bbde_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + bbde_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + bbde_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bbde_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* sv/bbde_back.sv */
module bbde_back (
   input  logic                               clock,
   input  logic                               reset,
   input  bbde_pkg::q_head_type               q_head,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bbde_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [6:0] digit_char, [10:7] digit_value
   output logic                               rsp_tlast,
   output logic                               rsp_tuser    // [0] out_of_range
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                                state_ff, state_in;
   logic [bbde_pkg::PLACE_W-1:0]             k_ff, k_in;
   logic [bbde_pkg::VALUE_W-1:0]             rem_ff, rem_in;
   logic                                     started_ff, started_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [bbde_pkg::DIGIT_CHAR_W-1:0]        char_ff, char_in;
   logic [bbde_pkg::DIGIT_VALUE_W-1:0]       dval_ff, dval_in;
   logic                                     last_ff, last_in;
   logic                                     oor_ff, oor_in;

   logic                                     out_free;
   logic                                     neg;
   logic [bbde_pkg::TBL_W-1:0]               rem_ext;
   logic [bbde_pkg::TBL_W-1:0]               mag;
   logic [bbde_pkg::SEL_W-1:0]               j;
   logic [bbde_pkg::TBL_W-1:0]               diff;
   logic [bbde_pkg::TBL_W-1:0]               rem_step;
   logic [bbde_pkg::DIGIT_VALUE_W-1:0]       dmag;
   logic [bbde_pkg::DIGIT_VALUE_W-1:0]       digit;
   logic [bbde_pkg::DIGIT_CHAR_W-1:0]        digit_char;
   logic                                     emit;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // digit of the current place, worked on the magnitude of the remainder
   always_comb begin
      neg     = rem_ff[bbde_pkg::VALUE_W-1];
      rem_ext = {{(bbde_pkg::TBL_W-bbde_pkg::VALUE_W){rem_ff[bbde_pkg::VALUE_W-1]}}, rem_ff};
      mag     = neg ? (~rem_ext + bbde_pkg::TBL_W'(1)) : rem_ext;
      j       = '0;
      for (int i = 1; i <= bbde_pkg::DIGIT_MAX; i++) begin
         if (mag >= bbde_pkg::THR_TABLE[{k_ff, bbde_pkg::SEL_W'(i)}]) begin
            j = bbde_pkg::SEL_W'(i);
         end
      end
      diff     = mag - bbde_pkg::MULT_TABLE[{k_ff, j}];
      rem_step = neg ? (~diff + bbde_pkg::TBL_W'(1)) : diff;
      dmag     = {{(bbde_pkg::DIGIT_VALUE_W-bbde_pkg::SEL_W){1'b0}}, j};
      digit    = neg ? (~dmag + bbde_pkg::DIGIT_VALUE_W'(1)) : dmag;
      if (j == '0) begin
         digit_char = bbde_pkg::CHAR_ZERO;
      end else if (neg) begin
         digit_char = bbde_pkg::CHAR_NEG_BASE + bbde_pkg::DIGIT_CHAR_W'(j);
      end else begin
         digit_char = bbde_pkg::CHAR_ZERO + bbde_pkg::DIGIT_CHAR_W'(j);
      end
      // drop leading zeros, but always send the units digit
      emit = (j != '0) || started_ff || (k_ff == '0);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      dval_in      = dval_ff;
      last_in      = last_ff;
      oor_in       = oor_ff;
      q_pop        = 1'b0;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               if (q_head.item.err) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     char_in      = '0;
                     dval_in      = '0;
                     last_in      = 1'b1;
                     oor_in       = 1'b1;
                  end
               end else begin
                  q_pop      = 1'b1;
                  rem_in     = q_head.item.value;
                  k_in       = bbde_pkg::PLACE_W'(bbde_pkg::PLACES - 1);
                  started_in = 1'b0;
                  state_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // hold while a digit waits for the output slot
            if (!emit || out_free) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  char_in      = digit_char;
                  dval_in      = digit;
                  last_in      = k_ff == '0;
                  oor_in       = 1'b0;
                  started_in   = 1'b1;
               end
               rem_in = rem_step[bbde_pkg::VALUE_W-1:0];
               if (k_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff - bbde_pkg::PLACE_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         rem_ff       <= rem_in;
         started_ff   <= started_in;
         char_ff      <= char_in;
         dval_ff      <= dval_in;
         last_ff      <= last_in;
         oor_ff       <= oor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bbde_pkg::RSP_DATA_W-bbde_pkg::DIGIT_CHAR_W-bbde_pkg::DIGIT_VALUE_W){1'b0}},
                        dval_ff, char_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = oor_ff;

endmodule

/* sv/balanced_base9_digit_encoder.sv */
// Flow: an input transfer writes the 2-entry queue; the back-end sequencer loads the head
//   value, then walks the digit places from the top, skipping leading zero places without
//   output, and registers each digit for rsp_tvalid; it holds while a digit waits for the
//   output slot. An out-of-range item is popped as one flagged result with no sequencing.
//   The queue lets input transfers continue while the sequencer works.
// Reset: synchronous, active high; clears the queue and the sequencer, output goes idle.
module balanced_base9_digit_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bbde_pkg::REQ_DATA_W-1:0]    req_tdata,   // [29:0] value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bbde_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [6:0] digit_char, [10:7] digit_value
   output logic                               rsp_tlast,   // last
   output logic                               rsp_tuser    // [0] out_of_range
);

   logic                  push_valid;
   logic                  push_ready;
   bbde_pkg::item_type    push_item;
   bbde_pkg::q_head_type  q_head;
   logic                  q_pop;

   bbde_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   bbde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   bbde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   typedef struct {
      logic [bbde_pkg::DIGIT_CHAR_W-1:0]         ch;
      logic signed [bbde_pkg::DIGIT_VALUE_W-1:0] val;
      logic                                      last;
      logic                                      oor;
   } digit_result_type;

   localparam longint LIMIT_MAG = longint'(bbde_pkg::MAX_POWER);

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [bbde_pkg::REQ_DATA_W-1:0]    req_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [bbde_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                               rsp_tlast;
   logic                               rsp_tuser;

   digit_result_type expected_digits[$];
   int               error_count = 0;
   bit               allow_idle  = 1'b1;

   balanced_base9_digit_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Balanced nonary digits of one value, most significant first
   function automatic void predict_digits(input logic [bbde_pkg::VALUE_W-1:0] raw);
      longint           x;
      longint           mag;
      int               r;
      int               n;
      int               place_digit[bbde_pkg::NUM_DIGITS];
      digit_result_type d;
      x   = $signed(raw);
      mag = (x < 0) ? -x : x;
      if (mag > LIMIT_MAG) begin
         d.ch   = '0;
         d.val  = '0;
         d.last = 1'b1;
         d.oor  = 1'b1;
         expected_digits.push_back(d);
         return;
      end
      n = 0;
      do begin
         r = int'(((x % 9) + 9) % 9);
         if (r > bbde_pkg::DIGIT_MAX) r -= 9;
         x = (x - r) / 9;
         place_digit[n] = r;
         n++;
      end while (x != 0 && n < bbde_pkg::NUM_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
         r      = place_digit[k];
         d.ch   = (r >= 0) ?
                  bbde_pkg::CHAR_ZERO + bbde_pkg::DIGIT_CHAR_W'(r) :
                  bbde_pkg::CHAR_NEG_BASE + bbde_pkg::DIGIT_CHAR_W'(-r);
         d.val  = bbde_pkg::DIGIT_VALUE_W'(r);
         d.last = (k == 0);
         d.oor  = 1'b0;
         expected_digits.push_back(d);
      end
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want, got);
      error_count++;
   endtask

   task automatic send_value(input longint v);
      int gap;
      gap = (allow_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(bbde_pkg::REQ_DATA_W - bbde_pkg::VALUE_W){1'b0}},
                     bbde_pkg::VALUE_W'(v)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digits(bbde_pkg::VALUE_W'(v));
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_digits.size() != 0) @(posedge clock);
   endtask

   // Check every result transfer against the oldest expected digit
   always @(posedge clock) begin
      digit_result_type d;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digits.size() == 0) begin
            report_mismatch("unexpected result", 0, rsp_tdata);
         end else begin
            d = expected_digits.pop_front();
            if (rsp_tdata[6:0] !== d.ch)
               report_mismatch("digit_char", d.ch, rsp_tdata[6:0]);
            if ($signed(rsp_tdata[10:7]) !== d.val)
               report_mismatch("digit_value", d.val, $signed(rsp_tdata[10:7]));
            if (rsp_tlast !== d.last)
               report_mismatch("last", d.last, rsp_tlast);
            if (rsp_tuser !== d.oor)
               report_mismatch("out_of_range", d.oor, rsp_tuser);
         end
      end
   end

   // Receiver stalls in random bursts
   initial begin
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 8) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic test_directed();
      longint pat[$];
      pat = '{0, 1, -1, 4, -4, 5, -5, 9, -9, 81, 364, -364, 40, -40,
              123456789, -123456789, LIMIT_MAG, -LIMIT_MAG, LIMIT_MAG + 1,
              -(LIMIT_MAG + 1), 536870911, -536870912, 193710244, -193710245};
      foreach (pat[i]) send_value(pat[i]);
   endtask

   // Hold the sender until every digit has left
   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++) send_value($signed(bbde_pkg::VALUE_W'($urandom)));
      stop_sending();
      wait_drained();
      send_value(-1);
      send_value(0);
   endtask

   function automatic longint random_value();
      longint mag;
      longint p;
      bit     neg;
      neg = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: mag = $urandom_range(0, 387420489);
         4, 5, 6: begin
            p   = 1;
            repeat ($urandom_range(1, 6)) p *= 9;
            mag = $urandom_range(0, int'(p));
         end
         7: mag = neg ? $urandom_range(387420490, 536870912) :
                        $urandom_range(387420490, 536870911);
         8: return $signed(bbde_pkg::VALUE_W'($urandom));
         default: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p *= 9;
            mag = p + $urandom_range(0, 4) - 2;
            if (mag < 0) mag = 0;
         end
      endcase
      return neg ? -mag : mag;
   endfunction

   task automatic test_random();
      for (int i = 0; i < 110; i++) send_value(random_value());
   endtask

   // Last part: both sides at full rate
   task automatic test_back_to_back();
      allow_idle = 1'b0;
      for (int i = 0; i < 30; i++) send_value(random_value());
      stop_sending();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_pause();
      test_random();
      test_back_to_back();
      wait_drained();
      repeat (30) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #400000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
sv/bbde_pkg.sv
sv/bbde_front.sv
sv/bbde_queue.sv
sv/bbde_back.sv
sv/balanced_base9_digit_encoder.sv
tb/sv/testbench.sv
